// ===== hdl/dmec_pkg.sv =====
package dmec_pkg;

  // One input word of the converter.
  typedef struct packed {
    logic        mode;
    logic [63:0] float_in;
    logic [63:0] mantissa_in;
    logic [63:0] exponent_in;
  } dmec_in_t;

  // One result word of the converter.
  typedef struct packed {
    logic [63:0] float_out;
    logic [53:0] mantissa_out;
    logic [63:0] exponent_out;
  } dmec_out_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_NAN     = 2'd0;
  localparam logic [1:0] REG_POS_INF = 2'd1;
  localparam logic [1:0] REG_NEG_INF = 2'd2;

  localparam logic [63:0] NAN_CODE_RST     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_INF_CODE_RST = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_INF_CODE_RST = 64'h8000_0000_0000_0001;

  localparam logic [63:0] INF_BITS  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;

  // Reverse-mode exponents are saturated to this magnitude before combining.
  localparam int EXP_LIMIT = 5000;

endpackage

// ===== hdl/double_mantissa_exponent_convert.sv =====
// A result strobes out_valid once its start has passed v1_r, v2_r, v3_r and v4_r.
// Throughput: one word per cycle; busy is never raised, since the four-stage
// pipeline always advances and the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the pipeline and returns the three
// code registers to their reset values.
module double_mantissa_exponent_convert import dmec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  dmec_in_t    in_data,
  output logic        out_valid,
  output dmec_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] nan_code_r, pos_inf_code_r, neg_inf_code_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nan_code_r     <= NAN_CODE_RST;
      pos_inf_code_r <= POS_INF_CODE_RST;
      neg_inf_code_r <= NEG_INF_CODE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NAN:     nan_code_r     <= cfg_data;
        REG_POS_INF: pos_inf_code_r <= cfg_data;
        REG_NEG_INF: neg_inf_code_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Decode the float, take the magnitude of the mantissa and saturate the
  // exponent. Specials of both modes are resolved here.
  logic        v1_r, mode1_r, neg1_r, spec1_r;
  logic [63:0] mag1_r;      // forward: significand; reverse: |mantissa|
  logic [13:0] e1_r;        // signed exponent, forward or saturated
  logic [63:0] spec_f1_r, spec_e1_r;

  logic        s1_neg, s1_spec;
  logic [63:0] s1_mag, s1_spec_f, s1_spec_e;
  logic [13:0] s1_e;
  logic [10:0] s1_bexp;
  logic [51:0] s1_frac;
  logic signed [63:0] s1_ein;

  always_comb begin
    s1_bexp   = in_data.float_in[62:52];
    s1_frac   = in_data.float_in[51:0];
    s1_ein    = $signed(in_data.exponent_in);
    s1_spec   = 1'b0;
    s1_spec_f = '0;
    s1_spec_e = '0;
    s1_neg    = 1'b0;
    s1_mag    = '0;
    s1_e      = '0;
    if (!in_data.mode) begin
      s1_neg = in_data.float_in[63];
      if (s1_bexp == 11'h7FF) begin
        s1_spec   = 1'b1;
        s1_spec_e = (s1_frac != '0) ? nan_code_r :
                    (s1_neg ? neg_inf_code_r : pos_inf_code_r);
      end else if (s1_bexp == '0 && s1_frac == '0) begin
        s1_spec = 1'b1;
      end else if (s1_bexp == '0) begin
        s1_mag = {12'd0, s1_frac};
        s1_e   = -14'sd1074;
      end else begin
        s1_mag = {11'd0, 1'b1, s1_frac};
        s1_e   = 14'({3'd0, s1_bexp}) - 14'sd1075;
      end
    end else begin
      s1_neg = in_data.mantissa_in[63];
      s1_mag = s1_neg ? (64'd0 - in_data.mantissa_in) : in_data.mantissa_in;
      if (in_data.mantissa_in == '0) begin
        s1_spec = 1'b1;
        if (in_data.exponent_in == '0)              s1_spec_f = '0;
        else if (in_data.exponent_in == pos_inf_code_r) s1_spec_f = INF_BITS;
        else if (in_data.exponent_in == neg_inf_code_r) s1_spec_f = {1'b1, INF_BITS[62:0]};
        else                                        s1_spec_f = QNAN_BITS;
      end
      if (s1_ein > 64'(EXP_LIMIT))       s1_e = 14'(EXP_LIMIT);
      else if (s1_ein < -64'(EXP_LIMIT)) s1_e = -14'(EXP_LIMIT);
      else                               s1_e = s1_ein[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start;
    mode1_r   <= in_data.mode;
    neg1_r    <= s1_neg;
    spec1_r   <= s1_spec;
    mag1_r    <= s1_mag;
    e1_r      <= s1_e;
    spec_f1_r <= s1_spec_f;
    spec_e1_r <= s1_spec_e;
  end

  // ---------------------------------------------------------------- stage 2
  // Find the most significant set bit (reverse) and count the trailing zeros (forward) of the
  // magnitude, and register the shift plans.
  logic        v2_r, mode2_r, neg2_r, spec2_r;
  logic [63:0] mag2_r, spec_f2_r, spec_e2_r;
  logic [13:0] e2_r;
  logic [5:0]  msb2_r, tz2_r;

  logic [5:0] s2_msb, s2_tz;
  always_comb begin
    s2_msb = '0;
    for (int i = 0; i < 64; i++) if (mag1_r[i]) s2_msb = 6'(i);
    s2_tz = '0;
    for (int i = 63; i >= 0; i--) if (mag1_r[i]) s2_tz = 6'(i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    mode2_r   <= mode1_r;
    neg2_r    <= neg1_r;
    spec2_r   <= spec1_r;
    mag2_r    <= mag1_r;
    e2_r      <= e1_r;
    msb2_r    <= s2_msb;
    tz2_r     <= s2_tz;
    spec_f2_r <= spec_f1_r;
    spec_e2_r <= spec_e1_r;
  end

  // ---------------------------------------------------------------- stage 3
  // Forward: strip trailing zeros. Reverse: place the result lsb, shift and
  // gather the round and sticky information.
  logic        v3_r, mode3_r, neg3_r, spec3_r, ovf3_r, rnd3_r;
  logic [63:0] spec_f3_r, spec_e3_r;
  logic [53:0] q3_r;        // forward: odd significand; reverse: truncated q
  logic [13:0] e3_r;        // forward: exponent; reverse: lsb

  logic [13:0] s3_top, s3_lsb, s3_drop;
  logic [53:0] s3_q;
  logic        s3_rnd, s3_half, s3_sticky, s3_ovf;
  logic [127:0] s3_wide;

  always_comb begin
    s3_top    = 14'({8'd0, msb2_r}) + e2_r;
    s3_ovf    = $signed(s3_top) > 14'sd1023;
    s3_lsb    = ($signed(s3_top - 14'sd52) < -14'sd1074) ? -14'sd1074 : s3_top - 14'sd52;
    s3_drop   = s3_lsb - e2_r;
    s3_q      = '0;
    s3_rnd    = 1'b0;
    s3_half   = 1'b0;
    s3_sticky = 1'b0;
    s3_wide   = '0;
    if (!mode2_r) begin
      s3_q   = 54'(mag2_r >> tz2_r);
      s3_lsb = e2_r + 14'({8'd0, tz2_r});
    end else if ($signed(s3_drop) <= 0) begin
      s3_q = 54'(mag2_r << 6'(-s3_drop));
    end else if ($signed(s3_drop) < 14'sd65) begin
      // Drop is 1..64: split magnitude into kept and dropped bits.
      s3_wide   = {mag2_r, 64'd0} >> s3_drop[6:0];
      s3_q      = 54'(s3_wide[127:64]);
      s3_half   = s3_wide[63];
      s3_sticky = s3_wide[62:0] != '0;
      s3_rnd    = s3_half && (s3_sticky || s3_q[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    mode3_r   <= mode2_r;
    neg3_r    <= neg2_r;
    spec3_r   <= spec2_r;
    ovf3_r    <= s3_ovf;
    rnd3_r    <= s3_rnd;
    q3_r      <= s3_q;
    e3_r      <= s3_lsb;
    spec_f3_r <= spec_f2_r;
    spec_e3_r <= spec_e2_r;
  end

  // ---------------------------------------------------------------- stage 4
  // Reverse: round, renormalise and pack. Forward: apply the sign and emit mantissa and exponent.
  logic        v4_r;
  dmec_out_t   out4_r, s4_out;
  logic [54:0] s4_q;
  logic [13:0] s4_lsb, s4_biased;

  always_comb begin
    s4_out    = '0;
    s4_q      = {1'b0, q3_r} + 55'(rnd3_r);
    s4_lsb    = e3_r;
    s4_biased = '0;
    if (!mode3_r) begin
      if (spec3_r) s4_out.exponent_out = spec_e3_r;
      else begin
        s4_out.mantissa_out = neg3_r ? (54'd0 - q3_r) : q3_r;
        s4_out.exponent_out = 64'($signed(e3_r));
      end
    end else if (spec3_r) begin
      s4_out.float_out = spec_f3_r;
    end else if (ovf3_r) begin
      s4_out.float_out = {neg3_r, INF_BITS[62:0]};
    end else begin
      if (s4_q[53]) begin
        s4_q   = s4_q >> 1;
        s4_lsb = s4_lsb + 14'sd1;
      end
      if (s4_q[52]) begin
        s4_biased = s4_lsb + 14'sd1075;
        if ($signed(s4_biased) >= 14'sd2047)
          s4_out.float_out = {neg3_r, INF_BITS[62:0]};
        else
          s4_out.float_out = {neg3_r, s4_biased[10:0], s4_q[51:0]};
      end else begin
        s4_out.float_out = {neg3_r, 11'd0, s4_q[51:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    out4_r <= s4_out;
  end

  assign out_valid = v4_r;
  assign out_data  = out4_r;

  // Every accepted word must leave as a result strobe at the end of the pipeline.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##4 out_valid) else $error("result strobe missing");
  // No strobe appears without a valid word in stage 3 ahead of it.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(v3_r)) else $error("spurious result");
  // A forward result never carries a float pattern.
  a_fwd_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !$past(mode3_r)) |-> out_data.float_out == '0)
    else $error("forward result has float bits");

endmodule
